// ===== rtl/rlce_pkg.sv =====
// rlce_pkg: shared types and constants of the RGB leader cluster engine.
// No dependencies; the other rtl files except rlce_ram refer to it by scoped names.
package rlce_pkg;

    localparam int SAT_MEMBERS = 65536;
    localparam int RED_SPLIT   = 128;
    localparam int MAX_RESULTS = 32;
    localparam int SUM_W       = 25;
    localparam int CNT_W       = 17;
    localparam int THR_W       = 20;
    localparam int DIST_W      = 20;
    localparam int IDX_OUT_W   = 5;
    localparam logic [THR_W-1:0] THR_RESET = 20'd32000;
    localparam logic [4:0] DIV_STEPS = 5'd25;

    typedef enum logic [1:0] {
        KIND_PIXEL    = 2'd0,
        KIND_END_PASS = 2'd1,
        KIND_CLEAR    = 2'd2,
        KIND_IGNORE   = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_HIT,
        S_MISS,
        S_EMPTY,
        S_EP_RD,
        S_EP_LD,
        S_EP_DIV,
        S_EP_WR
    } state_t;

    typedef struct packed {
        logic [23:0]      centroid;
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
        logic [CNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] cluster_index;
        logic                 created;
        logic                 dropped;
        logic [7:0]           centroid_red;
        logic [7:0]           centroid_green;
        logic [7:0]           centroid_blue;
        logic [CNT_W-1:0]     member_count;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic latch_item;
        logic clear_used;
        logic scan_start;
        logic scan_run;
        logic hit_commit;
        logic miss_commit;
        logic empty_commit;
        logic ep_start;
        logic ep_read;
        logic div_start;
        logic div_step;
        logic ep_commit;
    } cmd_t;

    typedef struct packed {
        logic used_zero;
        logic hit;
        logic scan_done;
        logic div_done;
        logic ep_emit;
        logic ep_last;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/rlce_ifs.sv =====
// rlce_ifs: handshake channels of the engine (item, result, config write).
// Depends on rlce_pkg for field widths.
interface rlce_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, kind, red, green, blue, input ready);
    modport sink (input valid, kind, red, green, blue, output ready);
endinterface

interface rlce_result_if;
    logic                              valid;
    logic                              ready;
    logic [rlce_pkg::IDX_OUT_W-1:0]    cluster_index;
    logic                              created;
    logic                              dropped;
    logic [7:0]                        centroid_red;
    logic [7:0]                        centroid_green;
    logic [7:0]                        centroid_blue;
    logic [rlce_pkg::CNT_W-1:0]        member_count;
    logic                              last;
    modport source (output valid, cluster_index, created, dropped, centroid_red,
                    centroid_green, centroid_blue, member_count, last, input ready);
    modport sink (input valid, cluster_index, created, dropped, centroid_red,
                  centroid_green, centroid_blue, member_count, last, output ready);
endinterface

interface rlce_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [rlce_pkg::THR_W-1:0]   data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/rlce_ram.sv =====
// rlce_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module rlce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== rtl/rlce_div.sv =====
// rlce_div: restoring divider lane for centroid means, one quotient bit per cycle while step is high.
// Depends on rlce_pkg for sum and count widths.
module rlce_div (
    input  logic                       clk,
    input  logic                       start,
    input  logic                       step,
    input  logic [rlce_pkg::SUM_W-1:0] dividend,
    input  logic [rlce_pkg::CNT_W-1:0] divisor,
    output logic [rlce_pkg::SUM_W-1:0] quotient
);
    localparam int SW = rlce_pkg::SUM_W;
    localparam int CW = rlce_pkg::CNT_W;

    logic [SW-1:0] quot_reg, quot_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW:0]   trial;
    logic          ge;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[SW-1]};
        ge        = trial >= {1'b0, divisor};
        rem_next  = ge ? CW'(trial - {1'b0, divisor}) : trial[CW-1:0];
        quot_next = {quot_reg[SW-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
        end
        else if (step)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign quotient = quot_reg;
endmodule

// ===== rtl/rlce_datapath.sv =====
// rlce_datapath: cluster table, scan pipeline, mean dividers, result register.
// Depends on rlce_pkg, rlce_ifs, rlce_ram and rlce_div.
module rlce_datapath #(
    parameter int MAX_CLUSTERS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    rlce_item_if.sink             item,
    rlce_cfg_if.sink              cfg,
    output rlce_pkg::result_t     res,
    output logic                  res_valid,
    input  logic                  res_ready,
    input  rlce_pkg::cmd_t        cmd,
    output rlce_pkg::stat_t       stat
);
    localparam int IW = $clog2(MAX_CLUSTERS);
    localparam int CW = $clog2(MAX_CLUSTERS + 1);
    localparam int SW = rlce_pkg::SUM_W;
    localparam int NW = rlce_pkg::CNT_W;

    logic [rlce_pkg::THR_W-1:0] thr_reg;
    logic [CW-1:0] used_reg, issue_reg, ep_idx_reg;
    logic [7:0] pr_reg, pg_reg, pb_reg;
    logic p1_valid_reg, p2_valid_reg;
    logic [IW-1:0] p1_idx_reg, p2_idx_reg;
    rlce_pkg::entry_t p2_entry_reg, ep_entry_reg, ram_q, wr_data;
    logic [15:0] sq_r_reg, sq_g_reg, sq_b_reg, sq_r, sq_g, sq_b;
    logic sel_reg, sel;
    logic [4:0] div_cnt_reg;
    logic [SW-1:0] q_r, q_g, q_b;
    logic out_valid_reg;
    rlce_pkg::result_t res_reg, res_next;
    logic load_out, wr_en, advance, full, hit;
    logic [IW-1:0] wr_addr, rd_addr;
    logic [rlce_pkg::DIST_W-1:0] wsum;
    logic [23:0] pix, ep_cen;
    logic [7:0] shown;
    logic [6:0] idx_wide;

    // signed differences and squares against the entry just read
    function automatic logic [15:0] sq_diff(input logic [7:0] p, input logic [7:0] c);
        logic [8:0] d;
        logic [7:0] a;
        d = {1'b0, p} - {1'b0, c};
        a = d[8] ? 8'(-d) : d[7:0];
        return 16'(a * a);
    endfunction

    assign pix = {pr_reg, pg_reg, pb_reg};
    assign cfg.ready = 1'b1;
    assign full = used_reg == CW'(MAX_CLUSTERS);

    always_comb
    begin
        logic [8:0] dr;
        dr   = {1'b0, pr_reg} - {1'b0, ram_q.centroid[23:16]};
        sel  = dr[8] || !dr[7];
        sq_r = sq_diff(pr_reg, ram_q.centroid[23:16]);
        sq_g = sq_diff(pg_reg, ram_q.centroid[15:8]);
        sq_b = sq_diff(pb_reg, ram_q.centroid[7:0]);
    end

    always_comb
    begin
        if (sel_reg)
        begin
            wsum = 20'({sq_r_reg, 1'b0}) + 20'({sq_g_reg, 2'b0})
                 + 20'({sq_b_reg, 1'b0}) + 20'(sq_b_reg);
        end
        else
        begin
            wsum = 20'({sq_r_reg, 1'b0}) + 20'(sq_r_reg) + 20'({sq_g_reg, 2'b0})
                 + 20'({sq_b_reg, 1'b0});
        end
        hit = p2_valid_reg && (wsum < thr_reg);
    end

    assign advance = cmd.scan_run && !hit;
    assign rd_addr = cmd.ep_read ? ep_idx_reg[IW-1:0] : issue_reg[IW-1:0];

    rlce_ram #(.WIDTH($bits(rlce_pkg::entry_t)), .DEPTH(MAX_CLUSTERS)) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    rlce_div u_div_r (.clk(clk), .start(cmd.div_start), .step(cmd.div_step),
                      .dividend(ram_q.sum_r), .divisor(ep_entry_reg.count), .quotient(q_r));
    rlce_div u_div_g (.clk(clk), .start(cmd.div_start), .step(cmd.div_step),
                      .dividend(ram_q.sum_g), .divisor(ep_entry_reg.count), .quotient(q_g));
    rlce_div u_div_b (.clk(clk), .start(cmd.div_start), .step(cmd.div_step),
                      .dividend(ram_q.sum_b), .divisor(ep_entry_reg.count), .quotient(q_b));

    // divisor comes from ep_entry_reg, loaded in the same cycle as the dividends
    assign ep_cen = (ep_entry_reg.count != '0) ? {q_r[7:0], q_g[7:0], q_b[7:0]}
                                                : ep_entry_reg.centroid;
    assign shown  = (8'(used_reg) < 8'(rlce_pkg::MAX_RESULTS)) ? 8'(used_reg)
                                                                : 8'(rlce_pkg::MAX_RESULTS);

    always_comb
    begin
        rlce_pkg::entry_t e;
        e        = p2_entry_reg;
        wr_en    = 1'b0;
        wr_addr  = p2_idx_reg;
        wr_data  = e;
        res_next = res_reg;
        idx_wide = 7'(p2_idx_reg);
        if (cmd.hit_commit)
        begin
            if (!e.count[NW-1])
            begin
                e.count = e.count + NW'(1);
                e.sum_r = e.sum_r + SW'(pr_reg);
                e.sum_g = e.sum_g + SW'(pg_reg);
                e.sum_b = e.sum_b + SW'(pb_reg);
            end
            wr_en    = 1'b1;
            wr_data  = e;
            res_next = {idx_wide[4:0], 1'b0, 1'b0, e.centroid, e.count, 1'b1};
        end
        else if (cmd.miss_commit)
        begin
            idx_wide = 7'(used_reg);
            wr_en    = !full;
            wr_addr  = used_reg[IW-1:0];
            wr_data  = {pix, SW'(pr_reg), SW'(pg_reg), SW'(pb_reg), NW'(1)};
            if (full)
            begin
                res_next = {5'd0, 1'b0, 1'b1, pix, NW'(0), 1'b1};
            end
            else
            begin
                res_next = {idx_wide[4:0], 1'b1, 1'b0, pix, NW'(1), 1'b1};
            end
        end
        else if (cmd.empty_commit)
        begin
            res_next = {5'd0, 1'b0, 1'b0, 24'd0, NW'(0), 1'b1};
        end
        else if (cmd.ep_commit)
        begin
            idx_wide = 7'(ep_idx_reg);
            wr_en    = 1'b1;
            wr_addr  = ep_idx_reg[IW-1:0];
            wr_data  = {ep_cen, SW'(ep_cen[23:16]), SW'(ep_cen[15:8]),
                        SW'(ep_cen[7:0]), NW'(1)};
            res_next = {idx_wide[4:0], 1'b0, 1'b0, ep_cen, ep_entry_reg.count,
                        (8'(ep_idx_reg) + 8'd1) == shown};
        end
    end

    assign load_out = cmd.hit_commit || cmd.miss_commit || cmd.empty_commit
                   || (cmd.ep_commit && stat.ep_emit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= rlce_pkg::THR_RESET;
            used_reg      <= '0;
            issue_reg     <= '0;
            ep_idx_reg    <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                thr_reg <= cfg.data;
            end
            if (cmd.clear_used)
            begin
                used_reg <= '0;
            end
            else if (cmd.miss_commit && !full)
            begin
                used_reg <= used_reg + CW'(1);
            end
            if (cmd.scan_start)
            begin
                issue_reg    <= '0;
                p1_valid_reg <= 1'b0;
                p2_valid_reg <= 1'b0;
            end
            else if (advance)
            begin
                p1_valid_reg <= issue_reg != used_reg;
                p2_valid_reg <= p1_valid_reg;
                if (issue_reg != used_reg)
                begin
                    issue_reg <= issue_reg + CW'(1);
                end
            end
            if (cmd.ep_start)
            begin
                ep_idx_reg <= '0;
            end
            else if (cmd.ep_commit)
            begin
                ep_idx_reg <= ep_idx_reg + CW'(1);
            end
            if (cmd.div_start)
            begin
                div_cnt_reg <= rlce_pkg::DIV_STEPS;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - 5'd1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            pr_reg <= item.red;
            pg_reg <= item.green;
            pb_reg <= item.blue;
        end
        if (advance)
        begin
            p1_idx_reg   <= issue_reg[IW-1:0];
            p2_idx_reg   <= p1_idx_reg;
            p2_entry_reg <= ram_q;
            sq_r_reg     <= sq_r;
            sq_g_reg     <= sq_g;
            sq_b_reg     <= sq_b;
            sel_reg      <= sel;
        end
        if (cmd.div_start)
        begin
            ep_entry_reg <= ram_q;
        end
        if (load_out)
        begin
            res_reg <= res_next;
        end
    end

    assign res       = res_reg;
    assign res_valid = out_valid_reg;

    always_comb
    begin
        stat.used_zero = used_reg == '0;
        stat.hit       = hit;
        stat.scan_done = (issue_reg == used_reg) && !p1_valid_reg && !p2_valid_reg;
        stat.div_done  = div_cnt_reg == '0;
        stat.ep_emit   = 8'(ep_idx_reg) < 8'(rlce_pkg::MAX_RESULTS);
        stat.ep_last   = (ep_idx_reg + CW'(1)) == used_reg;
        stat.out_free  = !out_valid_reg || res_ready;
    end
endmodule

// ===== rtl/rlce_ctrl.sv =====
// rlce_ctrl: sequencer for scan, join/create, end pass and clear.
// Depends on rlce_pkg.
module rlce_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  logic [1:0]      item_kind,
    output logic            item_ready,
    input  rlce_pkg::stat_t stat,
    output rlce_pkg::cmd_t  cmd
);
    rlce_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlce_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            rlce_pkg::S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.latch_item = 1'b1;
                    unique case (rlce_pkg::kind_t'(item_kind))
                        rlce_pkg::KIND_PIXEL:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = rlce_pkg::S_SCAN;
                        end
                        rlce_pkg::KIND_END_PASS:
                        begin
                            cmd.ep_start = 1'b1;
                            state_next   = stat.used_zero ? rlce_pkg::S_EMPTY
                                                          : rlce_pkg::S_EP_RD;
                        end
                        rlce_pkg::KIND_CLEAR:
                        begin
                            cmd.clear_used = 1'b1;
                        end
                        rlce_pkg::KIND_IGNORE:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            rlce_pkg::S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.hit)
                begin
                    state_next = rlce_pkg::S_HIT;
                end
                else if (stat.scan_done)
                begin
                    state_next = rlce_pkg::S_MISS;
                end
            end
            rlce_pkg::S_HIT:
            begin
                if (stat.out_free)
                begin
                    cmd.hit_commit = 1'b1;
                    state_next     = rlce_pkg::S_IDLE;
                end
            end
            rlce_pkg::S_MISS:
            begin
                if (stat.out_free)
                begin
                    cmd.miss_commit = 1'b1;
                    state_next      = rlce_pkg::S_IDLE;
                end
            end
            rlce_pkg::S_EMPTY:
            begin
                if (stat.out_free)
                begin
                    cmd.empty_commit = 1'b1;
                    state_next       = rlce_pkg::S_IDLE;
                end
            end
            rlce_pkg::S_EP_RD:
            begin
                cmd.ep_read = 1'b1;
                state_next  = rlce_pkg::S_EP_LD;
            end
            rlce_pkg::S_EP_LD:
            begin
                cmd.div_start = 1'b1;
                state_next    = rlce_pkg::S_EP_DIV;
            end
            rlce_pkg::S_EP_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = rlce_pkg::S_EP_WR;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            rlce_pkg::S_EP_WR:
            begin
                if (!stat.ep_emit || stat.out_free)
                begin
                    cmd.ep_commit = 1'b1;
                    state_next    = stat.ep_last ? rlce_pkg::S_IDLE : rlce_pkg::S_EP_RD;
                end
            end
            default:
            begin
                state_next = rlce_pkg::S_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/rgb_leader_cluster_engine.sv =====
// rgb_leader_cluster_engine: top level of the RGB leader clustering engine.
// Depends on rlce_pkg, rlce_ifs, rlce_ctrl, rlce_datapath (rlce_ram, rlce_div).
//
//   channel  | dir | payload                                    | transfer when
//   ---------+-----+--------------------------------------------+----------------
//   item     | in  | kind, red, green, blue                     | valid && ready
//   result   | out | cluster_index, created, dropped, centroid, | valid && ready
//            |     | member_count, last                         |
//   cfg      | in  | data = join_threshold (20 bits)            | valid && ready
//
// Pixels: a scan pipeline reads one table entry per cycle and stops at the first
// match. An end pass works through the clusters one at a time with the 25-step
// restoring dividers that form the means.
// Reset: the cluster count goes to zero and the threshold to 32000; the table
// RAM is not cleared since only entries below the count are ever used.
// Stalls: items are taken only while the sequencer is idle; a result waits in
// the output register, and the engine holds before writing the next one.
// cfg is always ready and must only be written while the engine is idle.
module rgb_leader_cluster_engine #(
    parameter int MAX_CLUSTERS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    rlce_item_if.sink      item,
    rlce_result_if.source  result,
    rlce_cfg_if.sink       cfg
);
    rlce_pkg::cmd_t    cmd;
    rlce_pkg::stat_t   stat;
    rlce_pkg::result_t res;
    logic              res_valid;
    logic              item_ready;

    // sequencer: only control, no payload
    rlce_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_kind  (item.kind),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    assign item.ready = item_ready;

    // table, distance pipeline, dividers and result register
    rlce_datapath #(.MAX_CLUSTERS(MAX_CLUSTERS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (result.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign result.valid          = res_valid;
    assign result.cluster_index  = res.cluster_index;
    assign result.created        = res.created;
    assign result.dropped        = res.dropped;
    assign result.centroid_red   = res.centroid_red;
    assign result.centroid_green = res.centroid_green;
    assign result.centroid_blue  = res.centroid_blue;
    assign result.member_count   = res.member_count;
    assign result.last           = res.last;
endmodule

// ===== test/tb_rgb_leader_cluster_engine.sv =====
// tb_rgb_leader_cluster_engine: self-checking bench for the RGB leader cluster engine.
// Drives pixel, end-pass, clear and ignored transfers through the rlce_ifs channels
// and checks every result against an in-bench cluster table model; needs rlce_pkg.
`timescale 1ns / 100ps

module tb_rgb_leader_cluster_engine;
    import rlce_pkg::*;

    localparam int NCLU = 32;
    // Upper bound on cycles after the last result before a threshold write
    // (an end pass over a full table runs the dividers once per cluster).
    localparam int DRAIN_CYCLES = 40 * NCLU + 50;

    logic clk;
    logic rst_n;

    rlce_item_if   item ();
    rlce_result_if result ();
    rlce_cfg_if    cfg ();

    rgb_leader_cluster_engine #(.MAX_CLUSTERS(NCLU)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("timeout at %0t", $time);
        $display("tb_rgb_leader_cluster_engine: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Cluster table model: what the engine should hold after each transfer.
    // ------------------------------------------------------------------
    logic [23:0]      mdl_cent  [NCLU];
    logic [SUM_W-1:0] mdl_sum_r [NCLU];
    logic [SUM_W-1:0] mdl_sum_g [NCLU];
    logic [SUM_W-1:0] mdl_sum_b [NCLU];
    logic [CNT_W-1:0] mdl_cnt   [NCLU];
    int               mdl_used;
    logic [THR_W-1:0] mdl_thr;

    result_t pending_results[$];   // expected results, oldest first
    int      err_count;
    int      results_seen;
    int      joins_seen, creates_seen, drops_seen, passes_seen, sat_seen;

    // Weighted squared distance; weights swap on the signed red difference.
    function automatic int unsigned color_dist(logic [7:0] r, logic [7:0] g,
                                               logic [7:0] b, logic [23:0] c);
        int dr, dg, db;
        dr = int'(r) - int'(c[23:16]);
        dg = int'(g) - int'(c[15:8]);
        db = int'(b) - int'(c[7:0]);
        if (dr < RED_SPLIT)
            return 2 * dr * dr + 4 * dg * dg + 3 * db * db;
        return 3 * dr * dr + 4 * dg * dg + 2 * db * db;
    endfunction

    function automatic result_t mk_result(int idx, bit cr, bit dp, logic [23:0] col,
                                          int cnt, bit lst);
        result_t res;
        res.cluster_index  = idx[IDX_OUT_W-1:0];
        res.created        = cr;
        res.dropped        = dp;
        res.centroid_red   = col[23:16];
        res.centroid_green = col[15:8];
        res.centroid_blue  = col[7:0];
        res.member_count   = cnt[CNT_W-1:0];
        res.last           = lst;
        return res;
    endfunction

    // Append one expected result at the tail of the queue.
    task automatic expect_result(result_t r);
        pending_results = {pending_results, r};
    endtask

    // Advance the model by one accepted transfer and queue what it yields.
    task automatic cluster_update(kind_t k, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int i, shown;
        int unsigned cnt;
        logic [23:0] c;
        case (k)
            KIND_PIXEL:
            begin
                for (i = 0; i < mdl_used; i++)
                begin
                    if (color_dist(r, g, b, mdl_cent[i]) < mdl_thr)
                    begin
                        if (mdl_cnt[i] < SAT_MEMBERS)
                        begin
                            mdl_cnt[i]++;
                            mdl_sum_r[i] += r;
                            mdl_sum_g[i] += g;
                            mdl_sum_b[i] += b;
                        end
                        else
                            sat_seen++;
                        expect_result(mk_result(i, 0, 0, mdl_cent[i], mdl_cnt[i], 1));
                        joins_seen++;
                        return;
                    end
                end
                if (mdl_used < NCLU)
                begin
                    i = mdl_used;
                    mdl_used++;
                    mdl_cent[i]  = {r, g, b};
                    mdl_sum_r[i] = r;
                    mdl_sum_g[i] = g;
                    mdl_sum_b[i] = b;
                    mdl_cnt[i]   = 1;
                    expect_result(mk_result(i, 1, 0, {r, g, b}, 1, 1));
                    creates_seen++;
                end
                else
                begin
                    expect_result(mk_result(0, 0, 1, {r, g, b}, 0, 1));
                    drops_seen++;
                end
            end
            KIND_END_PASS:
            begin
                passes_seen++;
                if (mdl_used == 0)
                begin
                    expect_result(mk_result(0, 0, 0, 24'd0, 0, 1));
                    return;
                end
                shown = (mdl_used < MAX_RESULTS) ? mdl_used : MAX_RESULTS;
                for (i = 0; i < mdl_used; i++)
                begin
                    cnt = mdl_cnt[i];
                    c   = mdl_cent[i];
                    if (cnt != 0)
                    begin
                        c[23:16] = 8'(mdl_sum_r[i] / cnt);
                        c[15:8]  = 8'(mdl_sum_g[i] / cnt);
                        c[7:0]   = 8'(mdl_sum_b[i] / cnt);
                    end
                    mdl_cent[i]  = c;
                    mdl_sum_r[i] = c[23:16];
                    mdl_sum_g[i] = c[15:8];
                    mdl_sum_b[i] = c[7:0];
                    mdl_cnt[i]   = 1;
                    if (i < shown)
                        expect_result(mk_result(i, 0, 0, c, cnt, i + 1 == shown));
                end
            end
            KIND_CLEAR:
                mdl_used = 0;
            default: ;  // ignored kind: nothing changes
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, one long hold-off, check of every field.
    // ------------------------------------------------------------------
    bit rx_calm;          // no stalls while set
    bit rx_hold_req;      // ask for one long hold-off
    bit rx_hold_done;

    initial
    begin
        int hold;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req && !rx_hold_done)
            begin
                result.ready <= 1'b0;
                for (hold = 0; hold < 400; hold++)
                    @(posedge clk);
                rx_hold_done = 1'b1;
                result.ready <= 1'b1;
            end
            else
                result.ready <= rx_calm ? 1'b1 : ($urandom_range(99) >= 28);
        end
    end

    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && result.valid && result.ready)
        begin
            got.cluster_index  = result.cluster_index;
            got.created        = result.created;
            got.dropped        = result.dropped;
            got.centroid_red   = result.centroid_red;
            got.centroid_green = result.centroid_green;
            got.centroid_blue  = result.centroid_blue;
            got.member_count   = result.member_count;
            got.last           = result.last;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result %p", $time, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    err_count++;
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Item and threshold drivers.
    // ------------------------------------------------------------------
    bit tx_calm;

    // valid stays high after a transfer so the next item can follow at once;
    // whoever stops sending drops it.
    task automatic send_item(kind_t k, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while (!tx_calm && $urandom_range(99) < 28)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid <= 1'b1;
        item.kind  <= k;
        item.red   <= r;
        item.green <= g;
        item.blue  <= b;
        do
            @(posedge clk);
        while (!item.ready);
        cluster_update(k, r, g, b);
    endtask

    // Threshold writes only once the engine has gone quiet.
    task automatic set_threshold(logic [THR_W-1:0] thr);
        int n;
        n = 0;
        item.valid <= 1'b0;
        while (pending_results.size() != 0 && n < 200000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= thr;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        mdl_thr = thr;
    endtask

    // Pixels around a few seed colors so clusters gather members.
    task automatic send_near(logic [23:0] seed, int spread);
        int r, g, b;
        r = int'(seed[23:16]) + $urandom_range(2 * spread) - spread;
        g = int'(seed[15:8])  + $urandom_range(2 * spread) - spread;
        b = int'(seed[7:0])   + $urandom_range(2 * spread) - spread;
        r = r < 0 ? 0 : (r > 255 ? 255 : r);
        g = g < 0 ? 0 : (g > 255 ? 255 : g);
        b = b < 0 ? 0 : (b > 255 ? 255 : b);
        send_item(KIND_PIXEL, r[7:0], g[7:0], b[7:0]);
    endtask

    // Directed rows; want_idx < 0 means the predictor alone decides.
    typedef struct {
        kind_t      k;
        logic [7:0] r, g, b;
        int         want_idx;
        bit         want_created;
        bit         want_dropped;
    } step_row_t;

    step_row_t steps[] = '{
        '{KIND_END_PASS, 8'd0,   8'd0,   8'd0,   0, 0, 0},  // pass on empty table
        '{KIND_PIXEL,    8'd0,   8'd0,   8'd0,   0, 1, 0},  // first pixel opens 0
        '{KIND_PIXEL,    8'd255, 8'd255, 8'd255, 1, 1, 0},  // far corner opens 1
        '{KIND_PIXEL,    8'd1,   8'd2,   8'd3,   0, 0, 0},  // joins 0
        '{KIND_PIXEL,    8'd200, 8'd0,   8'd0,  -1, 0, 0},  // red diff >= 128
        '{KIND_PIXEL,    8'd0,   8'd0,   8'd200,-1, 0, 0},
        '{KIND_PIXEL,    8'd254, 8'd250, 8'd255,-1, 0, 0},
        '{KIND_IGNORE,   8'd9,   8'd9,   8'd9,  -1, 0, 0},  // ignored kind
        '{KIND_END_PASS, 8'd0,   8'd0,   8'd0,  -1, 0, 0},
        '{KIND_PIXEL,    8'd128, 8'd128, 8'd128,-1, 0, 0},
        '{KIND_PIXEL,    8'd127, 8'd0,   8'd255,-1, 0, 0},
        '{KIND_END_PASS, 8'd0,   8'd0,   8'd0,  -1, 0, 0},
        '{KIND_CLEAR,    8'd0,   8'd0,   8'd0,  -1, 0, 0},  // empty the table
        '{KIND_PIXEL,    8'd55,  8'd170, 8'd85,  0, 1, 0}   // reopens at 0
    };

    initial
    begin
        int i, j, n;
        logic [23:0] seeds[4];
        result_t tail;

        rst_n        = 1'b0;
        item.valid   = 1'b0;
        item.kind    = KIND_PIXEL;
        item.red     = '0;
        item.green   = '0;
        item.blue    = '0;
        cfg.valid    = 1'b0;
        cfg.data     = '0;
        rx_calm      = 1'b0;
        tx_calm      = 1'b0;
        rx_hold_req  = 1'b0;
        rx_hold_done = 1'b0;
        err_count    = 0;
        results_seen = 0;
        joins_seen = 0; creates_seen = 0; drops_seen = 0; passes_seen = 0; sat_seen = 0;
        mdl_used     = 0;
        mdl_thr      = THR_RESET;
        for (i = 0; i < NCLU; i++)
        begin
            mdl_cent[i] = '0; mdl_sum_r[i] = '0; mdl_sum_g[i] = '0;
            mdl_sum_b[i] = '0; mdl_cnt[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, reset threshold; typed-in fields checked here too.
        foreach (steps[i])
        begin
            n = pending_results.size();
            send_item(steps[i].k, steps[i].r, steps[i].g, steps[i].b);
            if (steps[i].want_idx >= 0 && pending_results.size() > n)
            begin
                tail = pending_results[$];
                if (tail.cluster_index != steps[i].want_idx
                    || tail.created != steps[i].want_created
                    || tail.dropped != steps[i].want_dropped)
                begin
                    err_count++;
                    $display("%0t: row %0d expected idx %0d created %0b dropped %0b actual %p",
                             $time, i, steps[i].want_idx, steps[i].want_created,
                             steps[i].want_dropped, tail);
                end
            end
        end

        // Threshold 0: nothing ever joins; fill the table, overflow it, pass.
        set_threshold(20'd0);
        for (i = 0; i < NCLU + 3; i++)
            send_item(KIND_PIXEL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
        send_item(KIND_END_PASS, 8'd0, 8'd0, 8'd0);
        send_item(KIND_CLEAR, 8'd0, 8'd0, 8'd0);

        // Maximum threshold: everything lands in cluster 0.
        set_threshold(20'hFFFFF);
        for (i = 0; i < 12; i++)
            send_item(KIND_PIXEL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
        send_item(KIND_END_PASS, 8'd0, 8'd0, 8'd0);

        // Backpressure: hold the result side while items keep coming.
        set_threshold(20'd585226);
        rx_hold_req = 1'b1;
        tx_calm     = 1'b1;
        for (i = 0; i < 10; i++)
            send_item(KIND_PIXEL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
        tx_calm = 1'b0;
        send_item(KIND_CLEAR, 8'd0, 8'd0, 8'd0);

        // Random phases: clustered sequences with passes, some noise.
        for (j = 0; j < 4; j++)
        begin
            case (j)
                0: set_threshold(20'd2000);
                1: set_threshold(THR_RESET);
                2: set_threshold(20'($urandom_range(585226)));
                default: set_threshold(20'd300);
            endcase
            rx_calm = (j == 1);
            tx_calm = (j == 1);
            for (i = 0; i < 4; i++)
                seeds[i] = 24'($urandom);
            for (i = 0; i < 75; i++)
            begin
                n = $urandom_range(99);
                if (n < 70)
                    send_near(seeds[$urandom_range(3)], 12);
                else if (n < 85)
                    send_item(KIND_PIXEL, 8'($urandom_range(255)),
                              8'($urandom_range(255)), 8'($urandom_range(255)));
                else if (n < 94)
                    send_item(KIND_END_PASS, 8'($urandom), 8'($urandom), 8'($urandom));
                else if (n < 97)
                    send_item(KIND_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
                else
                    send_item(KIND_IGNORE, 8'($urandom), 8'($urandom), 8'($urandom));
            end
            send_item(KIND_END_PASS, 8'd0, 8'd0, 8'd0);
        end
        rx_calm = 1'b0;

        // Drain and let the engine settle.
        item.valid <= 1'b0;
        n = 0;
        while (pending_results.size() != 0 && n < 200000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d results: %0d joins, %0d new clusters, %0d drops, %0d passes",
                 results_seen, joins_seen, creates_seen, drops_seen, passes_seen);
        $display("threshold swept from 0 to max; one long result hold-off applied");
        if (err_count == 0 && pending_results.size() == 0)
            $display("tb_rgb_leader_cluster_engine: clean");
        else
        begin
            $display("%0d errors, %0d results never seen", err_count,
                     pending_results.size());
            $display("tb_rgb_leader_cluster_engine: errors");
        end
        $finish;
    end

endmodule

// ===== rgb_leader_cluster_engine.f =====
rtl/rlce_pkg.sv
rtl/rlce_ifs.sv
rtl/rlce_ram.sv
rtl/rlce_div.sv
rtl/rlce_datapath.sv
rtl/rlce_ctrl.sv
rtl/rgb_leader_cluster_engine.sv
test/tb_rgb_leader_cluster_engine.sv
